[sv/zmp_pkg.sv]
// zmp_pkg: widths, reset value of gravity and helper functions for the
// zero moment point block. No dependencies.

package zmp_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // field widths
    localparam int MASS_W = 32;
    localparam int POS_W  = 32;
    localparam int GRAV_W = 22;
    localparam int RES_W  = 32;
    localparam int IN_W   = MASS_W + 6 * POS_W;
    localparam int OUT_W  = 2 * RES_W;

    // shared multiplier: 33 x 33 signed
    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;

    // mass product after the fraction shift, split in two for the multiplier
    localparam int MF_W    = MASS_W + OP_W - FRAC_BITS;
    localparam int MF_LO_W = (MF_W + 1) / 2;
    localparam int MF_HI_W = MF_W - MF_LO_W;

    // term accumulator, sums and divider
    localparam int TERM_W = PROD_W + MF_LO_W + 1;
    localparam int SUM_W  = 64;
    localparam int DIFF_W = SUM_W + 1;
    localparam int NUM_W  = DIFF_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W);

    // gravity reset: round(9.8 * 2^FRAC_BITS), saturated to the register width
    localparam logic [63:0] GRAV_RAW = ((64'd98 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] GRAV_MAX = (64'd1 << GRAV_W) - 64'd1;
    localparam logic [GRAV_W-1:0] GRAV_RESET =
        GRAV_W'((GRAV_RAW > GRAV_MAX) ? GRAV_MAX : GRAV_RAW);

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // upper part of the mass product, sign extended to a multiplier operand
    function automatic logic [OP_W-1:0] mf_hi(input logic [MF_W-1:0] mf);
        return {{(OP_W-MF_HI_W){mf[MF_W-1]}}, mf[MF_W-1:MF_LO_W]};
    endfunction

    // lower part of the mass product, zero extended
    function automatic logic [OP_W-1:0] mf_lo(input logic [MF_W-1:0] mf);
        return {{(OP_W-MF_LO_W){1'b0}}, mf[MF_LO_W-1:0]};
    endfunction

    // signed 64-bit saturating add
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    // term: shift out the fraction, floor, then saturate to 64 bits
    function automatic logic [SUM_W-1:0] term_sat(input logic [TERM_W-1:0] t);
        logic [TERM_W-1:0] sh;
        logic [TERM_W-SUM_W:0] top;
        sh  = TERM_W'($signed(t) >>> FRAC_BITS);
        top = sh[TERM_W-1:SUM_W-1];
        if ((&top) || !(|top))
        begin
            return sh[SUM_W-1:0];
        end
        return sh[TERM_W-1] ? SUM_MIN : SUM_MAX;
    endfunction

endpackage

[sv/zero_moment_point.sv]
// zero_moment_point: accumulates the five moment sums of one frame and divides
// them out on the last segment. Depends on zmp_pkg.
//
//  channel  | dir | fields (lowest bit first)
//  ---------+-----+---------------------------------------------------------
//  s_*      | in  | tdata: seg_mass, pos_x, pos_y, pos_z, acc_x, acc_y, acc_z
//           |     | tlast: last_segment
//  m_*      | out | tdata: zmp_x, zmp_z   tuser: div_fault
//  cfg_*    | in  | data: gravity
//
// A segment is accepted on one input beat and then runs on the shared
// 33 x 33 multiplier (seven products, the four position products in two
// halves each); s_tready is low meanwhile, so the next segment waits.
// The last segment of a frame then runs the two restoring divisions at
// Q16.16, one quotient bit a cycle.
// A result waits in the output register; the next frame's result waits for
// it to be taken. Reset clears the sums, loads the gravity default.

module zero_moment_point (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // seg_mass, pos_x, pos_y, pos_z, acc_x, acc_y, acc_z
    input  logic [zmp_pkg::IN_W-1:0]   s_tdata,
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // zmp_x, zmp_z
    output logic [zmp_pkg::OUT_W-1:0]  m_tdata,
    // div_fault
    output logic                       m_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [zmp_pkg::GRAV_W-1:0] cfg_data
);
    import zmp_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_LATCH = 3'd2;
    localparam logic [2:0] ST_PREP  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // accumulation steps
    localparam logic [3:0] K_MW   = 4'd0;   // m * w
    localparam logic [3:0] K_MAX  = 4'd1;   // m * ax, sum c
    localparam logic [3:0] K_MAZ  = 4'd2;   // m * az
    localparam logic [3:0] K_AH   = 4'd3;   // a term, upper half
    localparam logic [3:0] K_AL   = 4'd4;
    localparam logic [3:0] K_DH   = 4'd5;
    localparam logic [3:0] K_DL   = 4'd6;   // sum a
    localparam logic [3:0] K_BH   = 4'd7;
    localparam logic [3:0] K_BL   = 4'd8;   // sum d
    localparam logic [3:0] K_EH   = 4'd9;
    localparam logic [3:0] K_EL   = 4'd10;  // sum b
    localparam logic [3:0] K_EADD = 4'd11;
    localparam logic [3:0] K_EUPD = 4'd12;  // sum e

    logic [2:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       sel_z_reg, sel_z_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    logic [GRAV_W-1:0] grav_reg;

    // captured segment
    logic [MASS_W-1:0] m_reg;
    logic [POS_W-1:0]  px_reg, py_reg, pz_reg, ax_reg, az_reg;
    logic [OP_W-1:0]   w_reg;
    logic              last_reg;

    // multiplier and term path
    logic signed [OP_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0] prod_full;
    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-1:0]        prod_sar;
    logic [MF_W-1:0]          mfw_reg, mfx_reg, mfz_reg;
    logic [TERM_W-1:0]        t_reg;
    logic [TERM_W-1:0]        t_load, t_add;
    logic [SUM_W-1:0]         term;

    logic [SUM_W-1:0] sum_a_reg, sum_b_reg, sum_c_reg, sum_d_reg, sum_e_reg;

    // divider
    logic [DIFF_W-1:0] diffx_reg, diffz_reg;
    logic [DIFF_W-1:0] diff_sel, diff_mag;
    logic [SUM_W-1:0]  d_reg;
    logic              c_neg_reg;
    logic              c_zero;
    logic [NUM_W-1:0]  n_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W:0]    trial, trial_sub;
    logic              ge;
    logic [RES_W-1:0]  q_reg;
    logic              ovf_reg;
    logic              neg_reg;
    logic [RES_W-1:0]  q_lim, q_sat, q_res;

    logic [RES_W-1:0] res_x_reg, res_z_reg;
    logic             fault_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    logic in_beat, out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign in_beat  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // operand selection for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            K_MW:    begin op_a = {1'b0, m_reg}; op_b = w_reg; end
            K_MAX:   begin op_a = {1'b0, m_reg}; op_b = {ax_reg[POS_W-1], ax_reg}; end
            K_MAZ:   begin op_a = {1'b0, m_reg}; op_b = {az_reg[POS_W-1], az_reg}; end
            K_AH:    begin op_a = mf_hi(mfw_reg); op_b = {px_reg[POS_W-1], px_reg}; end
            K_AL:    begin op_a = mf_lo(mfw_reg); op_b = {px_reg[POS_W-1], px_reg}; end
            K_DH:    begin op_a = mf_hi(mfw_reg); op_b = {pz_reg[POS_W-1], pz_reg}; end
            K_DL:    begin op_a = mf_lo(mfw_reg); op_b = {pz_reg[POS_W-1], pz_reg}; end
            K_BH:    begin op_a = mf_hi(mfx_reg); op_b = {py_reg[POS_W-1], py_reg}; end
            K_BL:    begin op_a = mf_lo(mfx_reg); op_b = {py_reg[POS_W-1], py_reg}; end
            K_EH:    begin op_a = mf_hi(mfz_reg); op_b = {py_reg[POS_W-1], py_reg}; end
            K_EL:    begin op_a = mf_lo(mfz_reg); op_b = {py_reg[POS_W-1], py_reg}; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod_full = op_a * op_b;
    assign prod_sar  = PROD_W'($signed(prod_reg) >>> FRAC_BITS);

    // upper half lands shifted, lower half is added on top
    assign t_load = {{(TERM_W-PROD_W-MF_LO_W){prod_reg[PROD_W-1]}}, prod_reg,
                     {MF_LO_W{1'b0}}};
    assign t_add  = t_reg + {{(TERM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign term   = term_sat(t_reg);

    // divider step and quotient finish
    assign c_zero    = (sum_c_reg == '0);
    assign diff_sel  = sel_z_reg ? diffz_reg : diffx_reg;
    assign diff_mag  = diff_sel[DIFF_W-1] ? (~diff_sel + 1'b1) : diff_sel;
    assign trial     = {rem_reg, n_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, d_reg};
    assign ge        = (trial >= {1'b0, d_reg});
    assign q_lim     = neg_reg ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    assign q_sat     = (ovf_reg || (q_reg > q_lim)) ? q_lim : q_reg;
    assign q_res     = neg_reg ? (~q_sat + 1'b1) : q_sat;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sel_z_next     = sel_z_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_ACC;
                    step_next  = K_MW;
                end
            end
            ST_ACC:
            begin
                if (step_reg == K_EUPD)
                begin
                    state_next = last_reg ? ST_LATCH : ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_LATCH:
            begin
                sel_z_next = 1'b0;
                state_next = c_zero ? ST_DONE : ST_PREP;
            end
            ST_PREP:
            begin
                cnt_next   = CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIN:
            begin
                if (sel_z_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sel_z_next = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= K_MW;
            sel_z_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sel_z_reg     <= sel_z_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // gravity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= GRAV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            grav_reg <= cfg_data;
        end
    end

    // segment capture, vertical force term w = acc_y + g
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            m_reg    <= s_tdata[0 +: MASS_W];
            px_reg   <= s_tdata[MASS_W + 0*POS_W +: POS_W];
            py_reg   <= s_tdata[MASS_W + 1*POS_W +: POS_W];
            pz_reg   <= s_tdata[MASS_W + 2*POS_W +: POS_W];
            ax_reg   <= s_tdata[MASS_W + 3*POS_W +: POS_W];
            az_reg   <= s_tdata[MASS_W + 5*POS_W +: POS_W];
            w_reg    <= {s_tdata[MASS_W + 5*POS_W - 1], s_tdata[MASS_W + 4*POS_W +: POS_W]}
                        + {{(OP_W-GRAV_W){1'b0}}, grav_reg};
            last_reg <= s_tlast;
        end
    end

    // product register, mass products and term accumulator
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(prod_full);
        if (state_reg == ST_ACC)
        begin
            case (step_reg)
                K_MAX:                 mfw_reg <= prod_sar[MF_W-1:0];
                K_MAZ:                 mfx_reg <= prod_sar[MF_W-1:0];
                K_AH:                  mfz_reg <= prod_sar[MF_W-1:0];
                K_AL, K_DL, K_BL, K_EL: t_reg  <= t_load;
                K_DH, K_BH, K_EH, K_EADD: t_reg <= t_add;
                default:               t_reg   <= t_reg;
            endcase
        end
    end

    // moment sums, cleared once a frame is latched for division
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            sum_c_reg <= '0;
            sum_d_reg <= '0;
            sum_e_reg <= '0;
        end
        else if (state_reg == ST_LATCH)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            sum_c_reg <= '0;
            sum_d_reg <= '0;
            sum_e_reg <= '0;
        end
        else if (state_reg == ST_ACC)
        begin
            case (step_reg)
                K_MAX:   sum_c_reg <= sat_add(sum_c_reg, prod_sar[SUM_W-1:0]);
                K_DL:    sum_a_reg <= sat_add(sum_a_reg, term);
                K_BL:    sum_d_reg <= sat_add(sum_d_reg, term);
                K_EL:    sum_b_reg <= sat_add(sum_b_reg, term);
                K_EUPD:  sum_e_reg <= sat_add(sum_e_reg, term);
                default: sum_c_reg <= sum_c_reg;
            endcase
        end
    end

    // differences, divisor magnitude and the restoring divider
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LATCH:
            begin
                diffx_reg <= {sum_a_reg[SUM_W-1], sum_a_reg} - {sum_b_reg[SUM_W-1], sum_b_reg};
                diffz_reg <= {sum_d_reg[SUM_W-1], sum_d_reg} - {sum_e_reg[SUM_W-1], sum_e_reg};
                d_reg     <= sum_c_reg[SUM_W-1] ? (~sum_c_reg + 1'b1) : sum_c_reg;
                c_neg_reg <= sum_c_reg[SUM_W-1];
                fault_reg <= c_zero;
                res_x_reg <= '0;
                res_z_reg <= '0;
            end
            ST_PREP:
            begin
                n_reg   <= {diff_mag, {FRAC_BITS{1'b0}}};
                neg_reg <= diff_sel[DIFF_W-1] ^ c_neg_reg;
                rem_reg <= '0;
                q_reg   <= '0;
                ovf_reg <= 1'b0;
            end
            ST_DIV:
            begin
                n_reg   <= {n_reg[NUM_W-2:0], 1'b0};
                rem_reg <= ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
                q_reg   <= {q_reg[RES_W-2:0], ge};
                ovf_reg <= ovf_reg | q_reg[RES_W-1];
            end
            ST_FIN:
            begin
                if (sel_z_reg)
                begin
                    res_z_reg <= q_res;
                end
                else
                begin
                    res_x_reg <= q_res;
                end
            end
            default:
            begin
                n_reg <= n_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {res_z_reg, res_x_reg};
            m_tuser_reg <= fault_reg;
        end
    end

endmodule

[tb/zero_moment_point_tb.sv]
// zero_moment_point_tb: self-checking bench for the zero moment point block.
// A directed table, then randomised frames over several gravity settings and
// idling patterns, results checked against typed rows or a local fixed-point model. Uses zmp_pkg.

module zero_moment_point_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import zmp_pkg::*;

    // gravity after reset: round(9.8 * 2^16)
    localparam logic [GRAV_W-1:0] GRAV_AT_RESET = 22'd642253;
    localparam logic [GRAV_W-1:0] GRAV_TOP      = 22'h3F_FFFF;

    // cycles for a segment plus both divisions, with margin
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 2500;

    localparam logic signed [129:0] S64_MAX = 130'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [129:0] S64_MIN = -S64_MAX - 130'sd1;
    localparam logic signed [129:0] Q32_MAX = 130'sh7FFF_FFFF;
    localparam logic signed [129:0] Q32_MIN = -Q32_MAX - 130'sd1;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] acc_x;
        logic [31:0] acc_y;
        logic [31:0] acc_z;
        logic        last;
    } segment_t;

    typedef struct packed {
        logic [31:0] zmp_x;
        logic [31:0] zmp_z;
        logic        fault;
    } zmp_t;

    typedef struct packed {
        segment_t sg;
        logic     typed;
        zmp_t     res;
    } dir_row_t;

    // directed rows: typed results only where obvious
    localparam int DIR_N = 20;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // massless segment: no vertical force
        '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}, 1'b1, '{32'h0, 32'h0, 1'b1}},
        // unit mass at x = 1, z = 2, at rest
        '{'{32'h1_0000, 32'h1_0000, 32'h0, 32'h2_0000, 32'h0, 32'h0, 32'h0, 1'b1},
          1'b1, '{32'h1_0000, 32'h2_0000, 1'b0}},
        // free fall cancels gravity exactly
        '{'{32'h1_0000, 32'h1_0000, 32'h3_0000, 32'h0, 32'h5_0000, 32'hFFF6_3333, 32'h0, 1'b1},
          1'b1, '{32'h0, 32'h0, 1'b1}},
        // two segments whose vertical forces cancel
        '{'{32'h1_0000, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
          1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'h1_0000, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'hFFEC_6666, 32'h0, 1'b1},
          1'b1, '{32'h0, 32'h0, 1'b1}},
        // field extremes
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        // tiny vertical force, large moments: quotient saturation both ways
        '{'{32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h0, 32'h8000_0000, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h0, 32'h7FFF_FFFF, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        // all ones: floor rounding of negative products
        '{'{32'h1_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        // positive sum saturation over three segments
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        // negative sum saturation over three segments
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        // plausible body: three segments
        '{'{32'h5_8000, 32'h1EB8, 32'hE666, 32'hFFFF_F334, 32'h1_8000,
            32'hFFFE_0000, 32'hC000, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'hC_4000, 32'hFFFF_EB85, 32'h1_199A, 32'h3333, 32'hFFFF_8000,
            32'h3_0000, 32'hFFFE_C000, 1'b0}, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{'{32'h2_0000, 32'h0CCD, 32'h4000, 32'hFFFF_E666, 32'h0,
            32'hFFFF_0000, 32'h2_0000, 1'b1}, 1'b0, '{32'h0, 32'h0, 1'b0}}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [GRAV_W-1:0]   cfg_data;

    // model state
    logic signed [63:0]  sum_a, sum_b, sum_c, sum_d, sum_e;
    logic [GRAV_W-1:0]   grav_cfg;
    zmp_t                expected_zmp [$];
    zmp_t                zmp_head;
    int                  n_fail;

    // receiver control
    int                  stall_pct;
    int                  hold_left;
    bit                  hold_req;

    zero_moment_point u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // signed saturation to 64 bits
    function automatic logic signed [63:0] clamp64(input logic signed [129:0] v);
        if (v > S64_MAX)
        begin
            return S64_MAX[63:0];
        end
        if (v < S64_MIN)
        begin
            return S64_MIN[63:0];
        end
        return v[63:0];
    endfunction

    // exact product, floor shift by the fraction, saturate
    function automatic logic signed [63:0] mul_shift(input logic signed [129:0] a,
                                                     input logic signed [129:0] b);
        logic signed [129:0] p;
        p = a * b;
        return clamp64(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] s,
                                                   input logic signed [63:0] t);
        logic signed [129:0] x, y;
        x = s;
        y = t;
        return clamp64(x + y);
    endfunction

    // ((hi - lo) << frac) / den, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] ratio32(input logic signed [63:0] hi,
                                            input logic signed [63:0] lo,
                                            input logic signed [63:0] den);
        logic signed [129:0] n, d, q;
        n = hi;
        d = lo;
        n = (n - d) <<< FRAC_BITS;
        d = den;
        q = n / d;
        if (q > Q32_MAX)
        begin
            return 32'h7FFF_FFFF;
        end
        if (q < Q32_MIN)
        begin
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    // accumulate one segment; on the last one form the zero moment point
    function automatic bit predict_zmp(input segment_t sg, output zmp_t r);
        logic signed [129:0] m, w;
        logic signed [63:0]  mw, mx, mz;
        m  = $signed({98'd0, sg.mass});
        w  = $signed(sg.acc_y);
        w  = w + $signed({108'd0, grav_cfg});
        mw = mul_shift(m, w);
        mx = mul_shift(m, $signed(sg.acc_x));
        mz = mul_shift(m, $signed(sg.acc_z));
        sum_a = add_sat(sum_a, mul_shift(mw, $signed(sg.pos_x)));
        sum_b = add_sat(sum_b, mul_shift(mx, $signed(sg.pos_y)));
        sum_c = add_sat(sum_c, mw);
        sum_d = add_sat(sum_d, mul_shift(mw, $signed(sg.pos_z)));
        sum_e = add_sat(sum_e, mul_shift(mz, $signed(sg.pos_y)));
        r = '0;
        if (!sg.last)
        begin
            return 1'b0;
        end
        if (sum_c == 64'sd0)
        begin
            r.fault = 1'b1;
        end
        else
        begin
            r.zmp_x = ratio32(sum_a, sum_b, sum_c);
            r.zmp_z = ratio32(sum_d, sum_e, sum_c);
        end
        sum_a = '0;
        sum_b = '0;
        sum_c = '0;
        sum_d = '0;
        sum_e = '0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] span(input int r);
        int v;
        v = int'($urandom_range(0, 2 * r)) - r;
        return v;
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly plausible bodies, some raw noise, extremes, zero-force and heavy segments
    function automatic segment_t random_segment(input bit last);
        segment_t sg;
        int       kind;
        kind     = $urandom_range(0, 99);
        sg.last  = last;
        sg.mass  = $urandom_range(0, 32'h0040_0000);
        sg.pos_x = span(32'h0003_0000);
        sg.pos_y = span(32'h0003_0000);
        sg.pos_z = span(32'h0003_0000);
        sg.acc_x = span(32'h0014_0000);
        sg.acc_y = span(32'h0014_0000);
        sg.acc_z = span(32'h0014_0000);
        if (kind >= 55 && kind < 72)
        begin
            sg.mass  = $urandom;
            sg.pos_x = $urandom;
            sg.pos_y = $urandom;
            sg.pos_z = $urandom;
            sg.acc_x = $urandom;
            sg.acc_y = $urandom;
            sg.acc_z = $urandom;
        end
        else if (kind >= 72 && kind < 84)
        begin
            sg.mass  = edge_value();
            sg.pos_x = edge_value();
            sg.pos_y = edge_value();
            sg.pos_z = edge_value();
            sg.acc_x = edge_value();
            sg.acc_y = edge_value();
            sg.acc_z = edge_value();
        end
        else if (kind >= 84 && kind < 92)
        begin
            // no vertical force from this segment
            if (kind[0])
            begin
                sg.mass = '0;
            end
            else
            begin
                sg.acc_y = 32'h0 - {10'd0, grav_cfg};
            end
        end
        else if (kind >= 92)
        begin
            sg.mass  = $urandom | 32'h8000_0000;
            sg.acc_y = $urandom;
        end
        return sg;
    endfunction

    // offer one segment beat and predict on acceptance
    task automatic send_segment(input segment_t sg, input bit typed, input zmp_t typed_res);
        zmp_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {sg.acc_z, sg.acc_y, sg.acc_x, sg.pos_z, sg.pos_y, sg.pos_x, sg.mass};
        s_tlast  <= sg.last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (predict_zmp(sg, r))
        begin
            expected_zmp = {expected_zmp, (typed ? typed_res : r)};
        end
    endtask

    task automatic write_gravity(input logic [GRAV_W-1:0] g);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        grav_cfg = g;
        cfg_valid <= 1'b0;
    endtask

    // wait for every result, then let the divider finish anything in flight
    task automatic drain_results();
        while (expected_zmp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n_items, input int idle_pct, input int stall,
                             input bit long_hold, input bit mid_pause);
        segment_t sg;
        zmp_t     none;
        int       seg_left;
        bit       pause_now;
        none      = '0;
        seg_left  = 0;
        stall_pct = stall;
        for (int i = 0; i < n_items; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 4);
            end
            // every phase ends on a frame boundary
            if (i == n_items - 1)
            begin
                seg_left = 1;
            end
            if (long_hold && i == n_items / 3)
            begin
                hold_req = 1'b1;
            end
            sg = random_segment(seg_left == 1);
            seg_left--;
            send_segment(sg, 1'b0, none);
            pause_now = mid_pause && (i == n_items / 2);
            if (pause_now || ($urandom_range(0, 99) < idle_pct))
            begin
                s_tvalid <= 1'b0;
                if (pause_now)
                begin
                    do @(posedge clk); while (expected_zmp.size() != 0);
                end
                else
                begin
                    do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // result side ready: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_zmp.size() == 0)
            begin
                $display("%0t: unexpected result beat zmp_x=%h zmp_z=%h fault=%b",
                         $time, m_tdata[31:0], m_tdata[63:32], m_tuser);
                n_fail++;
            end
            else
            begin
                zmp_head = expected_zmp.pop_front();
                if (m_tdata[31:0] !== zmp_head.zmp_x)
                begin
                    $display("%0t: zmp_x expected %h actual %h",
                             $time, zmp_head.zmp_x, m_tdata[31:0]);
                    n_fail++;
                end
                if (m_tdata[63:32] !== zmp_head.zmp_z)
                begin
                    $display("%0t: zmp_z expected %h actual %h",
                             $time, zmp_head.zmp_z, m_tdata[63:32]);
                    n_fail++;
                end
                if (m_tuser !== zmp_head.fault)
                begin
                    $display("%0t: div_fault expected %b actual %b",
                             $time, zmp_head.fault, m_tuser);
                    n_fail++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        stall_pct = 0;
        hold_left = 0;
        hold_req  = 1'b0;
        n_fail    = 0;
        grav_cfg  = GRAV_AT_RESET;
        sum_a     = '0;
        sum_b     = '0;
        sum_c     = '0;
        sum_d     = '0;
        sum_e     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset gravity, back to back
        for (int i = 0; i < DIR_N; i++)
        begin
            send_segment(DIR_ROWS[i].sg, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end
        s_tvalid <= 1'b0;

        // random frames under several gravity settings and idling patterns
        drain_results();
        write_gravity('0);
        run_phase(130, 0, 0, 1'b0, 1'b0);
        drain_results();
        write_gravity(GRAV_TOP);
        run_phase(130, 57, 0, 1'b0, 1'b1);
        drain_results();
        write_gravity(GRAV_W'($urandom_range(0, 32'h3F_FFFF)));
        run_phase(130, 0, 57, 1'b1, 1'b0);
        drain_results();
        write_gravity(GRAV_AT_RESET);
        run_phase(130, 22, 22, 1'b0, 1'b1);
        drain_results();
        write_gravity(GRAV_W'($urandom_range(0, 32'h3F_FFFF)));
        run_phase(110, 0, 0, 1'b1, 1'b0);
        drain_results();

        if (n_fail == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/zmp_pkg.sv
sv/zero_moment_point.sv
tb/zero_moment_point_tb.sv
